>>> rtl/ffc_pkg.sv
package ffc_pkg;

	// defaults for the top-level parameters
	localparam int DEF_MAX_TAPS       = 7;
	localparam int DEF_SAMPLE_BITS    = 16;
	localparam int DEF_COEF_FRAC_BITS = 12;

	// fixed field widths
	localparam int COEF_W     = 16;
	localparam int TAP_W      = 3;
	localparam int ACC_BITS   = 34;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W  = 3;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd1;

	localparam logic [TAP_W-1:0] TAP_COUNT_RESET = 3'd3;

	// shift control handed to every cell of the chain
	typedef struct packed {
		logic push;  // one word enters the chain
		logic clear; // last word of a sequence: empty the delay line behind it
	} shift_ctl_t;

endpackage

>>> rtl/ffc_cell.sv
// One tap: multiplies the sample at its position and holds it for the next cell.
module ffc_cell #(
	parameter int SAMPLE_BITS = ffc_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  ffc_pkg::shift_ctl_t                           ctl,
	input  logic signed [SAMPLE_BITS-1:0]                 tap_in,
	input  logic signed [ffc_pkg::COEF_W-1:0]             coef,
	output logic signed [SAMPLE_BITS+ffc_pkg::COEF_W-1:0] prod_s1,
	output logic signed [SAMPLE_BITS-1:0]                 tap_out
);

	logic signed [SAMPLE_BITS-1:0] d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (ctl.push) begin
			d_q <= ctl.clear ? '0 : tap_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			prod_s1 <= tap_in * coef;
		end
	end

	assign tap_out = d_q;

endmodule

>>> rtl/ffc_sum.sv
// Registered binary adder tree over the tap products.
module ffc_sum #(
	parameter int N     = ffc_pkg::DEF_MAX_TAPS,
	parameter int IN_W  = 32,
	parameter int OUT_W = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic                    in_fin,
	input  logic signed [IN_W-1:0]  prod [N],
	output logic                    out_vld,
	output logic                    out_fin,
	output logic signed [OUT_W-1:0] sum
);

	localparam int LEVELS = $clog2(N);
	localparam int P      = 1 << LEVELS;

	logic signed [OUT_W-1:0] leaf   [P];
	logic signed [OUT_W-1:0] tree_s [LEVELS][P];
	logic                    vld_s  [LEVELS];
	logic                    fin_s  [LEVELS];

	genvar l, i;

	generate
		for (i = 0; i < P; i++) begin : g_leaf
			if (i < N) begin : g_used
				assign leaf[i] = {{(OUT_W-IN_W){prod[i][IN_W-1]}}, prod[i]};
			end else begin : g_pad
				assign leaf[i] = '0;
			end
		end

		for (l = 0; l < LEVELS; l++) begin : g_lvl
			for (i = 0; i < (P >> (l + 1)); i++) begin : g_node
				if (l == 0) begin : g_first
					always_ff @(posedge clk) begin
						tree_s[0][i] <= leaf[2*i] + leaf[2*i+1];
					end
				end else begin : g_next
					always_ff @(posedge clk) begin
						tree_s[l][i] <= tree_s[l-1][2*i] + tree_s[l-1][2*i+1];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEVELS; k++) begin
				vld_s[k] <= 1'b0;
				fin_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_vld;
			fin_s[0] <= in_fin;
			for (int k = 1; k < LEVELS; k++) begin
				vld_s[k] <= vld_s[k-1];
				fin_s[k] <= fin_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[LEVELS-1];
	assign out_fin = fin_s[LEVELS-1];
	assign sum     = tree_s[LEVELS-1][0];

endmodule

>>> rtl/ffc_fifo.sv
// Small output queue; head word read straight from the register array.
module ffc_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);

endmodule

>>> rtl/full_fir_convolution.sv
// Streaming full-length FIR convolution. Each sample word on the slave side gives one
// output word on the master side: the exact sum of coef_k times the sample k steps back,
// for k below tap_count (0 read as 1, values above MAX_TAPS read as MAX_TAPS), with
// samples before the start of a sequence taken as zero. A sample with tlast set also
// produces tap_count-1 tail words as if zeros followed; the last word of the sequence
// carries tlast, and the delay line is then empty for the next sequence. Output is
// signed with COEF_FRAC_BITS fractional bits, low 34 bits of the exact sum.
// Rate: one word per cycle in and out while the output queue has room; s_tready is low
// while the tail words of a sequence are generated. Each result passes through the product
// register in each cell, the registered adder tree and the output queue. Coefficients and
// tap_count are to be written through cfg_we/cfg_addr/cfg_wdata only while no words are
// in flight; the block itself does not enforce this.
module full_fir_convolution #(
	parameter int MAX_TAPS       = ffc_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_BITS    = ffc_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = ffc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// sample stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic                                     s_tlast,  // seq_end
	// result stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [ffc_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [33:0] acc_value
	output logic                                     m_tlast,  // final_out
	// configuration
	input  logic                                     cfg_we,
	input  logic [ffc_pkg::CFG_IDX_W-1:0]            cfg_addr,
	input  logic [ffc_pkg::COEF_W-1:0]               cfg_wdata
);

	localparam int TAP_W   = ffc_pkg::TAP_W;
	localparam int COEF_W  = ffc_pkg::COEF_W;
	localparam int ACC_BITS = ffc_pkg::ACC_BITS;
	localparam int PROD_W  = SAMPLE_BITS + COEF_W;
	localparam int LEVELS  = $clog2(MAX_TAPS);
	localparam int ACC_W   = (PROD_W + LEVELS > ACC_BITS) ? PROD_W + LEVELS : ACC_BITS;
	localparam int Q_DEPTH = 1 << $clog2(LEVELS + 4);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	// reset kernel {0.5, 1.0, 0.5}
	localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(32'd1 << COEF_FRAC_BITS);
	localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'((32'd1 << COEF_FRAC_BITS) >> 1);

	// configuration registers
	logic [TAP_W-1:0]         tap_count_q;
	logic signed [COEF_W-1:0] coef_q   [MAX_TAPS];
	logic signed [COEF_W-1:0] coef_eff [MAX_TAPS];
	logic [TAP_W-1:0]         taps_c;

	// word issue control
	logic [TAP_W-1:0]         tail_q;     // tail words still to issue
	logic [CNT_W-1:0]         inflight_q; // words issued and not yet taken
	logic                     credit_ok;
	logic                     in_tail;
	logic                     push;
	logic                     push_final;
	ffc_pkg::shift_ctl_t      ctl;
	logic                     vld_s1;
	logic                     fin_s1;
	logic                     pop;

	// cell chain
	logic signed [SAMPLE_BITS-1:0] tap  [MAX_TAPS+1];
	logic signed [PROD_W-1:0]      prod [MAX_TAPS];

	logic                     sum_vld;
	logic                     sum_fin;
	logic signed [ACC_W-1:0]  sum;
	logic [ACC_BITS:0]        q_rd_data;
	logic                     q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= ffc_pkg::TAP_COUNT_RESET;
		end else if (cfg_we && cfg_addr == ffc_pkg::REG_TAP_COUNT) begin
			tap_count_q <= cfg_wdata[TAP_W-1:0];
		end
	end

	genvar k;
	generate
		for (k = 0; k < MAX_TAPS; k++) begin : g_coef
			localparam logic [COEF_W-1:0] RST =
				(k == 0 || k == 2) ? COEF_HALF : ((k == 1) ? COEF_ONE : '0);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q[k] <= RST;
				end else if (cfg_we &&
						cfg_addr == ffc_pkg::CFG_IDX_W'(ffc_pkg::REG_COEF_0 + k)) begin
					coef_q[k] <= cfg_wdata;
				end
			end

			// taps beyond the count in use contribute nothing
			assign coef_eff[k] = (TAP_W'(k) < taps_c) ? coef_q[k] : '0;
		end
	endgenerate

	always_comb begin
		if (tap_count_q == '0) begin
			taps_c = TAP_W'(1);
		end else if (tap_count_q > TAP_W'(MAX_TAPS)) begin
			taps_c = TAP_W'(MAX_TAPS);
		end else begin
			taps_c = tap_count_q;
		end
	end

	// a word is issued only while the output queue is sure to have room for it
	assign credit_ok  = (inflight_q < CNT_W'(Q_DEPTH));
	assign in_tail    = (tail_q != '0);
	assign s_tready   = credit_ok && !in_tail;
	assign push       = credit_ok && (in_tail || s_tvalid);
	assign push_final = in_tail ? (tail_q == TAP_W'(1))
	                            : (s_tlast && taps_c == TAP_W'(1));
	assign tap[0]     = in_tail ? '0 : s_tdata[SAMPLE_BITS-1:0];
	assign ctl.push   = push;
	assign ctl.clear  = push_final;
	assign pop        = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q     <= '0;
			inflight_q <= '0;
			vld_s1     <= 1'b0;
			fin_s1     <= 1'b0;
		end else begin
			if (push) begin
				if (in_tail) begin
					tail_q <= tail_q - TAP_W'(1);
				end else if (s_tlast && taps_c != TAP_W'(1)) begin
					tail_q <= taps_c - TAP_W'(1);
				end
			end
			inflight_q <= inflight_q + CNT_W'(push) - CNT_W'(pop);
			vld_s1     <= push;
			fin_s1     <= push_final;
		end
	end

	generate
		for (k = 0; k < MAX_TAPS; k++) begin : g_cell
			ffc_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.tap_in (tap[k]),
				.coef   (coef_eff[k]),
				.prod_s1(prod[k]),
				.tap_out(tap[k+1])
			);
		end
	endgenerate

	ffc_sum #(
		.N    (MAX_TAPS),
		.IN_W (PROD_W),
		.OUT_W(ACC_W)
	) u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s1),
		.in_fin (fin_s1),
		.prod   (prod),
		.out_vld(sum_vld),
		.out_fin(sum_fin),
		.sum    (sum)
	);

	ffc_fifo #(
		.WIDTH(ACC_BITS + 1),
		.DEPTH(Q_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (sum_vld),
		.wr_data  ({sum_fin, sum[ACC_BITS-1:0]}),
		.rd_en    (pop),
		.rd_data  (q_rd_data),
		.not_empty(q_not_empty)
	);

	assign m_tvalid = q_not_empty;
	assign m_tlast  = q_rd_data[ACC_BITS];
	assign m_tdata  = {{(ffc_pkg::OUT_TDATA_W-ACC_BITS){1'b0}}, q_rd_data[ACC_BITS-1:0]};

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(Q_DEPTH))
		else $error("more words in flight than the output queue holds");

	a_no_accept_in_tail: assert property (@(posedge clk) disable iff (!arst_n)
		in_tail |-> !s_tready)
		else $error("sample accepted while tail words are pending");

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_final |=> (tap[1] == '0 && tap[MAX_TAPS] == '0))
		else $error("delay line not cleared after end of sequence");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != '0)
		else $error("output word shown with nothing in flight");
`endif

endmodule

>>> sim/tb_top.sv
module tb_top;
	import ffc_pkg::*;

	// Full-convolution FIR: drives sample sequences in bursts, stalls the result
	// side on its own pattern and checks every result word against a predictor.

	localparam int WATCHDOG_LIMIT = 2000; // idle cycles before giving up
	localparam int LONG_HOLD      = 300;  // one long result-side stall
	localparam int DRAIN_SLACK    = 12;   // pipeline is 5 deep, keep some margin
	localparam int PHASES         = 6;
	localparam int PHASE_WORDS    = 22;

	typedef struct packed {
		logic [ACC_BITS-1:0] acc_value;
		logic                final_out;
	} conv_word_t;

	typedef enum {RX_FLOW, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

	// Predictor and store of outstanding convolution sums
	class conv_scoreboard;
		logic [TAP_W-1:0]         tap_cnt;
		logic signed [COEF_W-1:0] coef [7];
		logic signed [15:0]       history [6];   // earlier samples, newest first
		conv_word_t               pending_sums [$];
		int unsigned              mismatches;

		function new();
			tap_cnt = TAP_COUNT_RESET;
			foreach (coef[i]) coef[i] = '0;
			coef[0] = 16'(1 << (DEF_COEF_FRAC_BITS - 1));
			coef[1] = 16'(1 << DEF_COEF_FRAC_BITS);
			coef[2] = 16'(1 << (DEF_COEF_FRAC_BITS - 1));
			foreach (history[i]) history[i] = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
			if (idx == REG_TAP_COUNT)
				tap_cnt = value[TAP_W-1:0];
			else
				coef[idx - REG_COEF_0] = value;
		endfunction

		// one output for newest sample x, then x moves into the delay line
		function void shift_in(logic signed [15:0] x, int unsigned taps, logic fin);
			longint      acc;
			int unsigned k;
			acc = longint'(coef[0]) * longint'(x);
			for (k = 1; k < taps; k++)
				acc += longint'(coef[k]) * longint'(history[k-1]);
			for (k = 5; k > 0; k--)
				history[k] = history[k-1];
			history[0] = x;
			pending_sums.push_back('{acc_value: acc[ACC_BITS-1:0], final_out: fin});
		endfunction

		function void note_sample(logic signed [15:0] x, logic seq_end);
			int unsigned taps;
			int unsigned t;
			taps = (tap_cnt == 0) ? 1 : tap_cnt;  // zero taps reads as one
			shift_in(x, taps, seq_end && taps == 1);
			if (seq_end) begin
				// tail words as if zeros followed, then an empty delay line
				for (t = 1; t < taps; t++)
					shift_in('0, taps, t == taps - 1);
				foreach (history[i]) history[i] = '0;
			end
		endfunction

		function void check_output(logic [ACC_BITS-1:0] acc, logic fin);
			conv_word_t exp_w;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: acc %0d last %0b", $signed(acc), fin);
			end else begin
				exp_w = pending_sums.pop_front();
				if (exp_w.acc_value !== acc || exp_w.final_out !== fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected acc %0d last %0b, got acc %0d last %0b",
							$signed(exp_w.acc_value), exp_w.final_out, $signed(acc), fin);
				end
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
	logic [COEF_W-1:0]      cfg_wdata = '0;

	conv_scoreboard sb;
	int unsigned    burst_left = 0;
	int unsigned    idle_cycles = 0;
	bit             hold_go = 1'b0;

	full_fir_convolution u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [15:0] sample
		.s_tlast   (s_tlast),   // seq_end
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [33:0] acc_value
		.m_tlast   (m_tlast),   // final_out
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes sampled at the edge; the watchdog counts edges with no word moved
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata[ACC_BITS-1:0], m_tlast);
			if (s_tvalid && s_tready)
				sb.note_sample(s_tdata, s_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[full_fir_convolution] ERROR");
				$finish;
			end
		end
	end

	// Result side: segments of flow, coin-toss, rotating mask or light stalling,
	// plus one long hold once the main flow asks for it.
	initial begin : receiver
		rx_mode_t    mode;
		logic [7:0]  mask;
		int unsigned seg;
		bit          hold_taken;
		hold_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			mask = 8'($urandom);
			seg  = $urandom_range(8, 40);
			repeat (seg) begin
				@(posedge clk);
				if (hold_go && !hold_taken) begin
					hold_taken = 1'b1;
					m_tready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end else begin
					case (mode)
						RX_FLOW: m_tready <= 1'b1;
						RX_COIN: m_tready <= 1'($urandom_range(0, 1));
						RX_PATTERN: begin
							m_tready <= mask[0];
							mask = {mask[0], mask[7:1]};
						end
						default: m_tready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// One sample word; bursts of random length with random gaps between them
	task automatic send_sample(input logic [15:0] x, input logic seq_end);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		s_tlast  <= seq_end;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Back-to-back register writes; caller drops cfg_we afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic write_all_coefs(input logic [COEF_W-1:0] value);
		int unsigned k;
		for (k = 0; k < 7; k++)
			write_reg(REG_COEF_0 + CFG_IDX_W'(k), value);
	endtask

	// Wait until every expected word has arrived, then let the pipe go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin : main_flow
		int unsigned phase;
		int unsigned sent;
		int unsigned run_len;
		int unsigned j;
		int unsigned k;
		logic [2:0]  taps;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset kernel 0.5/1.0/0.5: extremes, then a one-sample sequence
		send_sample(16'h7fff, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hffff, 1'b1);
		send_sample(16'h7fff, 1'b1);
		drain();

		// all seven taps at most negative: largest positive sum
		write_reg(REG_TAP_COUNT, 16'd7);
		write_all_coefs(16'h8000);
		end_writes();
		repeat (7) send_sample(16'h8000, 1'b0);
		send_sample(16'h8000, 1'b1);
		drain();

		// most positive taps against most negative samples
		write_all_coefs(16'h7fff);
		end_writes();
		repeat (7) send_sample(16'h8000, 1'b0);
		send_sample(16'h7fff, 1'b1);
		drain();

		// tap count zero reads as one; garbage above the field is dropped
		write_reg(REG_TAP_COUNT, 16'hfff8);
		end_writes();
		send_sample(16'd5, 1'b0);
		send_sample(-16'sd5, 1'b1);
		drain();

		// single tap: every sequence end is one word marked last
		write_reg(REG_TAP_COUNT, 16'd1);
		end_writes();
		send_sample(16'h7fff, 1'b1);
		send_sample(16'h8000, 1'b1);
		drain();

		for (phase = 0; phase < PHASES; phase++) begin
			taps = 3'($urandom_range(0, 7));
			if (phase == PHASES - 1)
				taps = 3'd7;
			write_reg(REG_TAP_COUNT, (16'($urandom) & 16'hfff8) | 16'(taps));
			for (k = 0; k < 7; k++)
				write_reg(REG_COEF_0 + CFG_IDX_W'(k), pick_value());
			end_writes();
			// one long result-side stall while samples keep coming
			if (phase == 1)
				hold_go = 1'b1;
			sent = 0;
			while (sent < PHASE_WORDS) begin
				run_len = $urandom_range(1, 12);
				for (j = 0; j < run_len; j++)
					send_sample(pick_value(), j == run_len - 1);
				sent += run_len;
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_sums.size() == 0)
			$display("[full_fir_convolution] OK");
		else
			$display("[full_fir_convolution] ERROR");
		$finish;
	end

endmodule
